/* rtl/core/mpt_pkg.sv */
// package for the mailbox port table: types, status and opcode codes, defaults
// no dependencies
`default_nettype none
package mpt_pkg;

   localparam int PortCountDef = 16;
   localparam int RingDepthDef = 8;
   localparam int MaxWordsDef  = 4;
   localparam int WordBits     = 64;
   localparam int MsgBits      = 2 * WordBits + 3 + 4 * WordBits;

   localparam logic [1:0] OP_CREATE  = 2'd0;
   localparam logic [1:0] OP_SEND    = 2'd1;
   localparam logic [1:0] OP_RECEIVE = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_MESSAGE = 3'd1;
   localparam logic [2:0] ST_TABLE_FULL  = 3'd2;
   localparam logic [2:0] ST_BAD_PORT    = 3'd3;
   localparam logic [2:0] ST_QUEUE_FULL  = 3'd4;
   localparam logic [2:0] ST_WOULD_BLOCK = 3'd5;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] target_port;
      logic [63:0] owner_tag;
      logic [63:0] msg_sender;
      logic [63:0] msg_label;
      logic [2:0]  msg_length;
      logic [63:0] msg_word0;
      logic [63:0] msg_word1;
      logic [63:0] msg_word2;
      logic [63:0] msg_word3;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] new_port;
      logic [63:0] out_sender;
      logic [63:0] out_label;
      logic [2:0]  out_length;
      logic [63:0] out_word0;
      logic [63:0] out_word1;
      logic [63:0] out_word2;
      logic [63:0] out_word3;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic lookup;   // latch request and evaluate
      logic commit;   // apply table update and memory access
      logic finish;   // load response register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_read;  // ok receive: memory read in flight
   } stat_type;

endpackage
`default_nettype wire

/* rtl/core/mpt_ram.sv */
// generic single port ram with registered read
// no dependencies
`default_nettype none
module mpt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write or registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

/* rtl/core/mpt_ctrl.sv */
// controller for the mailbox port table: sequences lookup, commit, response
// depends on mpt_pkg
`default_nettype none
module mpt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire mpt_pkg::stat_type stat,
   output mpt_pkg::cmd_type       cmd
);
   import mpt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EVAL, S_READ, S_RESP} state_type;
   state_type state_ff;

   // request is taken when idle, or when the held response leaves this cycle
   assign req_ready = (state_ff == S_IDLE) || (state_ff == S_RESP && rsp_ready);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      cmd.lookup = req_valid && req_ready;
      cmd.commit = (state_ff == S_EVAL);
      cmd.finish = (state_ff == S_EVAL && !stat.is_read) || (state_ff == S_READ);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_EVAL;
            S_EVAL: state_ff <= stat.is_read ? S_READ : S_RESP;
            S_READ: state_ff <= S_RESP;
            S_RESP: begin
               if (rsp_ready) state_ff <= req_valid ? S_EVAL : S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_read_follows_eval: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> $past(state_ff) == S_EVAL) else $error("read out of order");
   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !cmd.commit) else $error("double commit");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL || state_ff == S_READ) |-> !req_ready) else $error("take busy");
`endif
endmodule
`default_nettype wire

/* rtl/core/mpt_dpath.sv */
// datapath for the mailbox port table: slot table, ring pointers, message store
// depends on mpt_pkg and mpt_ram
`default_nettype none
module mpt_dpath #(
   parameter int PortCount = mpt_pkg::PortCountDef,
   parameter int RingDepth = mpt_pkg::RingDepthDef,
   parameter int MaxWords  = mpt_pkg::MaxWordsDef
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mpt_pkg::req_type req_data,
   input  wire mpt_pkg::cmd_type cmd,
   output mpt_pkg::stat_type     stat,
   output mpt_pkg::rsp_type      rsp_data
);
   import mpt_pkg::*;

   localparam int SlotBits = (PortCount > 1) ? $clog2(PortCount) : 1;
   localparam int PtrBits  = $clog2(RingDepth);
   localparam int LvlBits  = $clog2(RingDepth + 1);
   localparam int AddrBits = $clog2(PortCount * RingDepth);
   localparam int Entries  = PortCount * RingDepth;

   // slot table
   logic [PortCount-1:0] used_ff;
   logic [63:0]          id_ff   [PortCount];
   logic [63:0]          owner_ff[PortCount];
   logic [PtrBits-1:0]   rptr_ff [PortCount];
   logic [PtrBits-1:0]   wptr_ff [PortCount];
   logic [LvlBits-1:0]   level_ff[PortCount];
   logic [63:0]          next_id_ff;

   req_type              req_ff;
   logic [2:0]           status_ff, status_in;
   logic [SlotBits-1:0]  slot_ff, slot_in;
   logic                 found_in;
   logic [SlotBits-1:0]  free_in;
   logic                 has_free_in;
   logic                 is_read_ff;
   logic                 wr_ff;
   logic [63:0]          new_port_ff;

   // parallel compare for the lowest matching slot and the lowest free slot
   always_comb begin
      found_in = 1'b0;
      slot_in = '0;
      has_free_in = 1'b0;
      free_in = '0;
      for (int i = PortCount - 1; i >= 0; i--) begin
         if (used_ff[i] && id_ff[i] == req_data.target_port) begin
            found_in = 1'b1;
            slot_in = SlotBits'(i);
         end
         if (!used_ff[i]) begin
            has_free_in = 1'b1;
            free_in = SlotBits'(i);
         end
      end
   end

   // status decision from table state at request accept
   always_comb begin
      status_in = ST_BAD_MESSAGE;
      case (req_data.opcode)
         OP_CREATE: status_in = has_free_in ? ST_OK : ST_TABLE_FULL;
         OP_SEND: begin
            if (32'(req_data.msg_length) > MaxWords) status_in = ST_BAD_MESSAGE;
            else if (!found_in) status_in = ST_BAD_PORT;
            else if (32'(level_ff[slot_in]) >= RingDepth) status_in = ST_QUEUE_FULL;
            else status_in = ST_OK;
         end
         OP_RECEIVE: begin
            if (!found_in) status_in = ST_BAD_PORT;
            else if (level_ff[slot_in] == '0) status_in = ST_WOULD_BLOCK;
            else status_in = ST_OK;
         end
         default: status_in = ST_BAD_MESSAGE;
      endcase
   end

   assign stat.is_read = is_read_ff;

   // latch the request and its evaluation
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         req_ff <= req_data;
         status_ff <= status_in;
         slot_ff <= (req_data.opcode == OP_CREATE) ? free_in : slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_read_ff <= 1'b0;
      end else if (cmd.lookup) begin
         is_read_ff <= (req_data.opcode == OP_RECEIVE) && (status_in == ST_OK);
      end
   end

   // table update at commit
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         next_id_ff <= 64'd1;
         for (int i = 0; i < PortCount; i++) begin
            rptr_ff[i] <= '0;
            wptr_ff[i] <= '0;
            level_ff[i] <= '0;
         end
      end else if (cmd.commit && status_ff == ST_OK) begin
         case (req_ff.opcode)
            OP_CREATE: begin
               used_ff[slot_ff] <= 1'b1;
               next_id_ff <= next_id_ff + 64'd1;
               rptr_ff[slot_ff] <= '0;
               wptr_ff[slot_ff] <= '0;
               level_ff[slot_ff] <= '0;
            end
            OP_SEND: begin
               wptr_ff[slot_ff] <= (wptr_ff[slot_ff] == PtrBits'(RingDepth - 1)) ? '0
                                   : wptr_ff[slot_ff] + PtrBits'(1);
               level_ff[slot_ff] <= level_ff[slot_ff] + LvlBits'(1);
            end
            OP_RECEIVE: begin
               rptr_ff[slot_ff] <= (rptr_ff[slot_ff] == PtrBits'(RingDepth - 1)) ? '0
                                   : rptr_ff[slot_ff] + PtrBits'(1);
               level_ff[slot_ff] <= level_ff[slot_ff] - LvlBits'(1);
            end
            default: ;
         endcase
      end
   end

   // id and owner payload
   always_ff @(posedge clock) begin
      if (cmd.commit && status_ff == ST_OK && req_ff.opcode == OP_CREATE) begin
         id_ff[slot_ff] <= next_id_ff;
         owner_ff[slot_ff] <= req_ff.owner_tag;
         new_port_ff <= next_id_ff;
      end else if (cmd.commit) begin
         new_port_ff <= '0;
      end
   end

   // message store: one ram, one access per request
   logic [AddrBits-1:0] addr;
   logic [MsgBits-1:0]  wr_msg, rd_msg;
   logic                wr_en;
   assign wr_en = cmd.commit && status_ff == ST_OK && req_ff.opcode == OP_SEND;
   assign addr = AddrBits'(32'(slot_ff) * RingDepth +
                 32'(req_ff.opcode == OP_SEND ? wptr_ff[slot_ff] : rptr_ff[slot_ff]));
   assign wr_msg = {req_ff.msg_sender, req_ff.msg_label, req_ff.msg_length,
                    req_ff.msg_word0, req_ff.msg_word1, req_ff.msg_word2, req_ff.msg_word3};

   mpt_ram #(.Width(MsgBits), .Depth(Entries)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr),
      .wr_data (wr_msg),
      .rd_data (rd_msg)
   );

   always_ff @(posedge clock) wr_ff <= wr_en;

   // response register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data.status <= status_ff;
         rsp_data.new_port <= cmd.commit ?
            ((status_ff == ST_OK && req_ff.opcode == OP_CREATE) ? next_id_ff : '0)
            : new_port_ff;
         if (!cmd.commit) begin
            {rsp_data.out_sender, rsp_data.out_label, rsp_data.out_length,
             rsp_data.out_word0, rsp_data.out_word1, rsp_data.out_word2,
             rsp_data.out_word3} <= rd_msg;
         end else begin
            {rsp_data.out_sender, rsp_data.out_label, rsp_data.out_length,
             rsp_data.out_word0, rsp_data.out_word1, rsp_data.out_word2,
             rsp_data.out_word3} <= '0;
         end
      end
   end

`ifndef ASSERT_OFF
   a_write_not_read: assert property (@(posedge clock) disable iff (reset)
      wr_ff |-> !is_read_ff) else $error("store write on a receive");
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> 32'(level_ff[slot_ff]) <= RingDepth) else $error("ring overfill");
   a_id_advance: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.commit) && $past(status_ff) == ST_OK && $past(req_ff.opcode) == OP_CREATE
      |-> next_id_ff == $past(next_id_ff) + 64'd1) else $error("id counter slip");
`endif
endmodule
`default_nettype wire

/* rtl/core/mailbox_port_table.sv */
// Mailbox port table: create ports, send to and receive from per-port message
// rings. One request at a time: create, send and failed requests go from the
// evaluate to the response state; a successful receive also passes the read
// state, for the registered read of the single message store RAM. A new request
// is taken in the cycle its predecessor's response is taken. Port lookup is a
// parallel compare across the slot table. No clearing pass after reset.
// depends on mpt_pkg, mpt_ctrl, mpt_dpath
`default_nettype none
module mailbox_port_table #(
   parameter int PortCount = mpt_pkg::PortCountDef,
   parameter int RingDepth = mpt_pkg::RingDepthDef,
   parameter int MaxWords  = mpt_pkg::MaxWordsDef
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mpt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mpt_pkg::rsp_type      rsp_data
);
   import mpt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mpt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   mpt_dpath #(.PortCount(PortCount), .RingDepth(RingDepth), .MaxWords(MaxWords))
   u_dpath (
      .clock, .reset, .req_data, .cmd, .stat, .rsp_data
   );
endmodule
`default_nettype wire

/* tb/sv/mailbox_port_table_tb.sv */
// testbench for mailbox_port_table: random and directed create, send and receive
// transactions checked against a behavioral model of the port table and rings
// depends on mpt_pkg and mailbox_port_table
`timescale 1ns / 100ps
`default_nettype none
module mailbox_port_table_tb;
   import mpt_pkg::*;

   localparam int NumPorts  = 16;
   localparam int Depth     = 8;
   localparam int MaxLen    = 4;
   localparam int IdleLimit = 5000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [63:0] sender;
      logic [63:0] label;
      logic [2:0]  length;
      logic [63:0] w0;
      logic [63:0] w1;
      logic [63:0] w2;
      logic [63:0] w3;
   } letter_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // model state
   logic        port_used [NumPorts];
   logic [63:0] port_id [NumPorts];
   letter_type  ring [NumPorts][$];
   logic [63:0] id_counter;

   req_type     pending_reqs [$];
   rsp_type     expected_rsps [$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          quiet_mode = 1'b0;
   bit          sender_hold = 1'b0;
   int          stall_left = 0;
   bit          stim_done = 1'b0;
   logic [63:0] known_ids [$];

   mailbox_port_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   function automatic int model_slot_of(logic [63:0] id);
      for (int i = 0; i < NumPorts; i++)
         if (port_used[i] && port_id[i] == id) return i;
      return -1;
   endfunction

   // apply one accepted request to the model and return its response
   function automatic rsp_type mailbox_predict(req_type r);
      rsp_type    rsp;
      letter_type l;
      int         s;
      rsp = '0;
      rsp.status = ST_BAD_MESSAGE;
      case (r.opcode)
         OP_CREATE: begin
            rsp.status = ST_TABLE_FULL;
            for (int i = 0; i < NumPorts; i++)
               if (!port_used[i]) begin
                  port_used[i] = 1'b1;
                  port_id[i] = id_counter;
                  ring[i].delete();
                  rsp.new_port = id_counter;
                  id_counter = id_counter + 64'd1;
                  rsp.status = ST_OK;
                  break;
               end
         end
         OP_SEND: begin
            s = model_slot_of(r.target_port);
            if (r.msg_length > MaxLen) rsp.status = ST_BAD_MESSAGE;
            else if (s < 0) rsp.status = ST_BAD_PORT;
            else if (ring[s].size() >= Depth) rsp.status = ST_QUEUE_FULL;
            else begin
               l = {r.msg_sender, r.msg_label, r.msg_length, r.msg_word0,
                    r.msg_word1, r.msg_word2, r.msg_word3};
               ring[s].push_back(l);
               rsp.status = ST_OK;
            end
         end
         OP_RECEIVE: begin
            s = model_slot_of(r.target_port);
            if (s < 0) rsp.status = ST_BAD_PORT;
            else if (ring[s].size() == 0) rsp.status = ST_WOULD_BLOCK;
            else begin
               l = ring[s].pop_front();
               rsp.out_sender = l.sender;
               rsp.out_label  = l.label;
               rsp.out_length = l.length;
               rsp.out_word0  = l.w0;
               rsp.out_word1  = l.w1;
               rsp.out_word2  = l.w2;
               rsp.out_word3  = l.w3;
               rsp.status = ST_OK;
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] pick_target();
      int c;
      c = $urandom_range(0, 19);
      if (c == 0) return rand64();
      if (c == 1) return 64'd0;
      if (known_ids.size() == 0) return rand64();
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
   endfunction

   function automatic req_type build_req(logic [1:0] op, logic [63:0] tgt, logic [2:0] len);
      req_type r;
      r = '0;
      r.opcode = op;
      r.target_port = tgt;
      r.owner_tag = rand64();
      r.msg_sender = rand64();
      r.msg_label = rand64();
      r.msg_length = len;
      r.msg_word0 = rand64();
      r.msg_word1 = rand64();
      r.msg_word2 = rand64();
      r.msg_word3 = rand64();
      return r;
   endfunction

   // driver: offers pending transactions, holds payload until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold
      end else if (pending_reqs.size() > 0 && !sender_hold &&
                   (quiet_mode || $urandom_range(0, 99) >= 7)) begin
         req_valid <= 1'b1;
         req_data  <= pending_reqs.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // predictor fed at each accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_rsps.push_back(mailbox_predict(req_data));
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_mode || ($urandom_range(0, 99) >= 7);
      end
   end

   // monitor: compare each response with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (e.status !== rsp_data.status || e.new_port !== rsp_data.new_port ||
                e.out_sender !== rsp_data.out_sender || e.out_label !== rsp_data.out_label ||
                e.out_length !== rsp_data.out_length || e.out_word0 !== rsp_data.out_word0 ||
                e.out_word1 !== rsp_data.out_word1 || e.out_word2 !== rsp_data.out_word2 ||
                e.out_word3 !== rsp_data.out_word3) begin
               $display("%0t: mismatch, expected %h, actual %h", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   // watchdog on accepted transactions
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (stim_done && expected_rsps.size() == 0) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      req_type     r;
      int          c;
      logic [63:0] ids_known_copy;
      for (int i = 0; i < NumPorts; i++) begin
         port_used[i] = 1'b0;
         port_id[i] = '0;
      end
      id_counter = 64'd1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, bad ports, unused opcode, long message
      pending_reqs.push_back(build_req(OP_SEND, 64'd1, 3'd0));
      pending_reqs.push_back(build_req(OP_RECEIVE, 64'd1, 3'd0));
      pending_reqs.push_back(build_req(OP_UNUSED, '1, 3'd7));
      pending_reqs.push_back(build_req(OP_SEND, 64'd1, 3'd5));
      r = build_req(OP_CREATE, '0, 3'd0);
      r.owner_tag = '1;
      pending_reqs.push_back(r);
      pending_reqs.push_back(build_req(OP_RECEIVE, 64'd1, 3'd0));
      // fill port 1 past its ring, with extreme payloads first
      r = build_req(OP_SEND, 64'd1, 3'd4);
      r.msg_sender = '1; r.msg_label = '1; r.msg_word0 = '1; r.msg_word1 = '1;
      r.msg_word2 = '1; r.msg_word3 = '1;
      pending_reqs.push_back(r);
      r = build_req(OP_SEND, 64'd1, 3'd0);
      r.msg_sender = '0; r.msg_label = '0; r.msg_word0 = '0; r.msg_word1 = '0;
      r.msg_word2 = '0; r.msg_word3 = '0;
      pending_reqs.push_back(r);
      for (int i = 0; i < 7; i++)
         pending_reqs.push_back(build_req(OP_SEND, 64'd1, 3'($urandom_range(0, 4))));
      pending_reqs.push_back(build_req(OP_SEND, 64'd1, 3'd7));
      for (int i = 0; i < 9; i++)
         pending_reqs.push_back(build_req(OP_RECEIVE, 64'd1, 3'd0));
      for (int i = 1; i <= NumPorts; i++) known_ids.push_back(64'(i));
      drain();

      // long receiver stall while the sender keeps offering
      for (int i = 0; i < 40; i++)
         pending_reqs.push_back(build_req(OP_CREATE, '0, 3'd0));
      stall_left <= 300;
      drain();

      // random traffic, with a quiet stretch and a sender pause midway
      for (int n = 0; n < 1100; n++) begin
         if (n == 300) begin
            drain();
            quiet_mode = 1'b1;
         end
         if (n == 500) begin
            drain();
            sender_hold = 1'b1;
            repeat (20) @(posedge clock);
            sender_hold = 1'b0;
            quiet_mode = 1'b0;
         end
         c = $urandom_range(0, 99);
         ids_known_copy = pick_target();
         if (c < 2)
            r = build_req(OP_CREATE, rand64(), 3'($urandom_range(0, 7)));
         else if (c < 4)
            r = build_req(OP_UNUSED, rand64(), 3'($urandom_range(0, 7)));
         else if (c < 52)
            r = build_req(OP_SEND, ids_known_copy,
                          ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4)));
         else
            r = build_req(OP_RECEIVE, ids_known_copy, 3'($urandom_range(0, 7)));
         pending_reqs.push_back(r);
         if (pending_reqs.size() > 20) wait (pending_reqs.size() < 10);
      end
      drain();
      stim_done = 1'b1;
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire
